### rtl/bwsu_pkg.sv
// shared constants and the partial binomial sum function for the
// bounded weight string unrank block; depends on nothing
package bwsu_pkg;

   localparam int RANK_W    = 33;   // width of the one-based rank
   localparam int BITS_W    = 32;   // width of the decoded string port
   localparam int CFG_W     = 6;    // width of each configuration register
   localparam int CSR_IDX_W = 2;    // width of the register index
   localparam int TAB_N     = 64;   // columns kept by the elaboration-time table
   localparam int TAB_W     = 64;   // width of an exact table entry

   localparam logic [CSR_IDX_W-1:0] REG_BIT_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ONES  = CSR_IDX_W'(1);

   // ranks never exceed 2^33 - 1, so table entries are clipped at 2^33
   localparam logic [RANK_W:0] W_LIMIT = {1'b1, {RANK_W{1'b0}}};

   // number of i-bit strings with at most j ones, clipped at W_LIMIT;
   // only ever called with constant arguments
   function automatic logic [RANK_W:0] wsum_sat(input int i, input int j);
      logic [TAB_W-1:0] row [0:TAB_N-1];
      logic [TAB_W-1:0] w;
      for (int c = 0; c < TAB_N; c++) begin
         row[c] = TAB_W'(1);
      end
      for (int r = 1; r <= i; r++) begin
         // descending so row[c-1] still holds the previous row
         for (int c = TAB_N - 1; c >= 1; c--) begin
            row[c] = row[c] + row[c-1];
         end
      end
      w = row[j];
      if (w > TAB_W'(W_LIMIT)) begin
         return W_LIMIT;
      end
      return w[RANK_W:0];
   endfunction

endpackage

### rtl/bwsu_stage.sv
// one bit position of the unrank pipeline: compare the remaining rank with
// the partial binomial sum of this row, subtract and set the bit; uses bwsu_pkg
module bwsu_stage #(
   parameter int MAX_BITS = 32,
   parameter int POS      = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [bwsu_pkg::RANK_W-1:0]     in_rank,
   input  logic [$clog2(MAX_BITS+1)-1:0]   in_len,
   input  logic [$clog2(MAX_BITS+1)-1:0]   in_ones,
   input  logic [MAX_BITS-1:0]             in_word,
   input  logic                            in_bad,
   output logic                            out_valid,
   output logic [bwsu_pkg::RANK_W-1:0]     out_rank,
   output logic [$clog2(MAX_BITS+1)-1:0]   out_len,
   output logic [$clog2(MAX_BITS+1)-1:0]   out_ones,
   output logic [MAX_BITS-1:0]             out_word,
   output logic                            out_bad
);

   localparam int NW = $clog2(MAX_BITS + 1);

   logic [bwsu_pkg::RANK_W:0]   row [0:MAX_BITS];
   logic [bwsu_pkg::RANK_W:0]   w;
   logic                        take;

   logic                        valid_ff;
   logic [bwsu_pkg::RANK_W-1:0] rank_ff, rank_in;
   logic [NW-1:0]               len_ff;
   logic [NW-1:0]               ones_ff, ones_in;
   logic [MAX_BITS-1:0]         word_ff, word_in;
   logic                        bad_ff, bad_in;

   // row POS of the table, one constant per weight bound
   for (genvar j = 0; j <= MAX_BITS; j++) begin : g_row
      localparam logic [bwsu_pkg::RANK_W:0] WV = bwsu_pkg::wsum_sat(POS, j);
      assign row[j] = WV;
   end

   always_comb begin
      w    = row[in_ones];
      // positions at or above the string length are skipped
      take = (in_len > NW'(POS)) && ({1'b0, in_rank} > w);
      rank_in = in_rank;
      ones_in = in_ones;
      word_in = in_word;
      bad_in  = in_bad;
      if (take) begin
         rank_in = in_rank - w[bwsu_pkg::RANK_W-1:0];
         word_in = in_word | (MAX_BITS'(1) << POS);
         if (in_ones != '0) begin
            ones_in = in_ones - NW'(1);
         end else begin
            // a one beyond the weight bound means the rank was too large
            bad_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rank_ff <= rank_in;
      len_ff  <= in_len;
      ones_ff <= ones_in;
      word_ff <= word_in;
      bad_ff  <= bad_in;
   end

   assign out_valid = valid_ff;
   assign out_rank  = rank_ff;
   assign out_len   = len_ff;
   assign out_ones  = ones_ff;
   assign out_word  = word_ff;
   assign out_bad   = bad_ff;

endmodule

### rtl/bounded_weight_string_unrank.sv
// top level of the bounded weight string unrank block: configuration
// registers, input stage, bit position pipeline and result register
// depends on bwsu_pkg and bwsu_stage
//
//   channel   ports                                   transfer when
//   --------  --------------------------------------  -------------------------
//   input     start, busy, req_rank                   start high, busy low
//   result    rsp_valid, rsp_bits, rsp_out_of_range   rsp_valid high (one cycle)
//   config    csr_we, csr_index, csr_wdata            csr_we high
//
// a new rank can be taken every cycle; busy is always low
// each rank passes the input register, one stage per bit position and the result register
// the chain of MAX_BITS compare-and-subtract stages sets the latency
// reset clears the valid bits and sets bit_count and max_ones to 8
// the pipeline never stalls since the receiver cannot hold results off
module bounded_weight_string_unrank #(
   parameter int MAX_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [bwsu_pkg::RANK_W-1:0]      req_rank,
   output logic                             rsp_valid,
   output logic [bwsu_pkg::BITS_W-1:0]      rsp_bits,
   output logic                             rsp_out_of_range,
   input  logic                             csr_we,
   input  logic [bwsu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bwsu_pkg::CFG_W-1:0]       csr_wdata
);

   localparam int NW = $clog2(MAX_BITS + 1);
   localparam int EW = bwsu_pkg::BITS_W + MAX_BITS;

   logic [bwsu_pkg::CFG_W-1:0]  bit_count_ff;
   logic [bwsu_pkg::CFG_W-1:0]  max_ones_ff;

   logic                        accept;
   logic [NW-1:0]               len_in;
   logic [NW-1:0]               ones_in;

   logic                        v_pipe    [0:MAX_BITS];
   logic [bwsu_pkg::RANK_W-1:0] rank_pipe [0:MAX_BITS];
   logic [NW-1:0]               len_pipe  [0:MAX_BITS];
   logic [NW-1:0]               ones_pipe [0:MAX_BITS];
   logic [MAX_BITS-1:0]         word_pipe [0:MAX_BITS];
   logic                        bad_pipe  [0:MAX_BITS];

   logic                        in_valid_ff;
   logic [bwsu_pkg::RANK_W-1:0] in_rank_ff;
   logic [NW-1:0]               in_len_ff;
   logic [NW-1:0]               in_ones_ff;

   logic                        fail;
   logic [EW-1:0]               word_ext;
   logic                        rsp_valid_ff;
   logic [bwsu_pkg::BITS_W-1:0] rsp_bits_ff, rsp_bits_in;
   logic                        rsp_oor_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= bwsu_pkg::CFG_W'(8);
         max_ones_ff  <= bwsu_pkg::CFG_W'(8);
      end else if (csr_we) begin
         case (csr_index)
            bwsu_pkg::REG_BIT_COUNT: bit_count_ff <= csr_wdata;
            bwsu_pkg::REG_MAX_ONES:  max_ones_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp length to MAX_BITS and weight bound to length
   always_comb begin
      if ({1'b0, bit_count_ff} > (bwsu_pkg::CFG_W + 1)'(MAX_BITS)) begin
         len_in = NW'(MAX_BITS);
      end else begin
         len_in = NW'(bit_count_ff);
      end
      if ({1'b0, max_ones_ff} > (bwsu_pkg::CFG_W + 1)'(len_in)) begin
         ones_in = len_in;
      end else begin
         ones_in = NW'(max_ones_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      in_rank_ff <= req_rank;
      in_len_ff  <= len_in;
      in_ones_ff <= ones_in;
   end

   assign v_pipe[0]    = in_valid_ff;
   assign rank_pipe[0] = in_rank_ff;
   assign len_pipe[0]  = in_len_ff;
   assign ones_pipe[0] = in_ones_ff;
   assign word_pipe[0] = '0;
   assign bad_pipe[0]  = 1'b0;

   // stage s decides bit position MAX_BITS-1-s
   for (genvar s = 0; s < MAX_BITS; s++) begin : g_stage
      bwsu_stage #(
         .MAX_BITS (MAX_BITS),
         .POS      (MAX_BITS - 1 - s)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v_pipe[s]),
         .in_rank   (rank_pipe[s]),
         .in_len    (len_pipe[s]),
         .in_ones   (ones_pipe[s]),
         .in_word   (word_pipe[s]),
         .in_bad    (bad_pipe[s]),
         .out_valid (v_pipe[s+1]),
         .out_rank  (rank_pipe[s+1]),
         .out_len   (len_pipe[s+1]),
         .out_ones  (ones_pipe[s+1]),
         .out_word  (word_pipe[s+1]),
         .out_bad   (bad_pipe[s+1])
      );
   end

   // an in-range rank always leaves exactly one behind
   always_comb begin
      fail     = bad_pipe[MAX_BITS] || (rank_pipe[MAX_BITS] != bwsu_pkg::RANK_W'(1));
      word_ext = EW'(word_pipe[MAX_BITS]);
      rsp_bits_in = fail ? '0 : word_ext[bwsu_pkg::BITS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= v_pipe[MAX_BITS];
      end
   end

   always_ff @(posedge clock) begin
      rsp_bits_ff <= rsp_bits_in;
      rsp_oor_ff  <= fail;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bits         = rsp_bits_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

### verif/bounded_weight_string_unrank_tb.sv
// self-checking testbench for bounded_weight_string_unrank: a scoreboard class
// predicts each decoded string from its own table of partial binomial sums
// depends on bwsu_pkg and the bounded_weight_string_unrank rtl
`timescale 1ns / 100ps

module bounded_weight_string_unrank_tb;

   localparam int MAX_BITS        = 32;
   localparam int LATENCY         = MAX_BITS + 2;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_PHASES   = 12;
   localparam int FIXED_PHASES    = 8;
   localparam int ITEMS_PER_PHASE = 150;

   // indexes past the register list, writes there must be ignored
   localparam logic [bwsu_pkg::CSR_IDX_W-1:0] REG_SPARE_LO = bwsu_pkg::CSR_IDX_W'(2);
   localparam logic [bwsu_pkg::CSR_IDX_W-1:0] REG_SPARE_HI = bwsu_pkg::CSR_IDX_W'(3);

   typedef struct {
      logic [bwsu_pkg::BITS_W-1:0] bits;
      logic                        out_of_range;
   } unrank_result_type;

   class unrank_checker;
      longint unsigned            wsum [0:MAX_BITS][0:MAX_BITS];
      logic [bwsu_pkg::CFG_W-1:0] length_reg;
      logic [bwsu_pkg::CFG_W-1:0] weight_reg;
      unrank_result_type          expected_strings [$];
      int                         mismatches;

      function new();
         for (int j = 0; j <= MAX_BITS; j++) begin
            wsum[0][j] = 1;
         end
         for (int i = 1; i <= MAX_BITS; i++) begin
            wsum[i][0] = 1;
            for (int j = 1; j <= MAX_BITS; j++) begin
               wsum[i][j] = wsum[i-1][j] + wsum[i-1][j-1];
            end
         end
         length_reg = bwsu_pkg::CFG_W'(8);
         weight_reg = bwsu_pkg::CFG_W'(8);
         mismatches = 0;
      endfunction

      function void write_reg(logic [bwsu_pkg::CSR_IDX_W-1:0] idx,
                              logic [bwsu_pkg::CFG_W-1:0] val);
         case (idx)
            bwsu_pkg::REG_BIT_COUNT: length_reg = val;
            bwsu_pkg::REG_MAX_ONES:  weight_reg = val;
            default: ;
         endcase
      endfunction

      function int eff_length();
         return (int'(length_reg) > MAX_BITS) ? MAX_BITS : int'(length_reg);
      endfunction

      function int eff_weight();
         return (int'(weight_reg) > eff_length()) ? eff_length() : int'(weight_reg);
      endfunction

      function longint unsigned string_total();
         return wsum[eff_length()][eff_weight()];
      endfunction

      function unrank_result_type decode_rank(logic [bwsu_pkg::RANK_W-1:0] rank);
         unrank_result_type res;
         longint unsigned   r;
         longint unsigned   w;
         logic [MAX_BITS-1:0] word;
         int                n;
         int                k;
         r = {31'b0, rank};
         n = eff_length();
         k = eff_weight();
         word = '0;
         res.out_of_range = 1'b0;
         if (r == 0 || r > wsum[n][k]) begin
            res.bits = '0;
            res.out_of_range = 1'b1;
            return res;
         end
         // msb first: a set bit skips every string with a zero there
         for (int p = n - 1; p >= 0; p--) begin
            w = wsum[p][k];
            if (r > w) begin
               word[p] = 1'b1;
               r = r - w;
               if (k > 0) k--;
            end
         end
         res.bits = word[bwsu_pkg::BITS_W-1:0];
         return res;
      endfunction

      function void note_rank(logic [bwsu_pkg::RANK_W-1:0] rank);
         expected_strings.push_back(decode_rank(rank));
      endfunction

      function void check_result(logic [bwsu_pkg::BITS_W-1:0] bits, logic out_of_range);
         unrank_result_type want;
         if (expected_strings.size() == 0) begin
            $error("result with no transfer outstanding: bits %h out_of_range %b",
                   bits, out_of_range);
            mismatches++;
            return;
         end
         want = expected_strings.pop_front();
         if (bits !== want.bits) begin
            $error("bits: expected %h, actual %h", want.bits, bits);
            mismatches++;
         end
         if (out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %b, actual %b", want.out_of_range, out_of_range);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_strings.size();
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic [bwsu_pkg::RANK_W-1:0]    req_rank = '0;
   logic                           rsp_valid;
   logic [bwsu_pkg::BITS_W-1:0]    rsp_bits;
   logic                           rsp_out_of_range;
   logic                           csr_we = 1'b0;
   logic [bwsu_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bwsu_pkg::CFG_W-1:0]     csr_wdata = '0;

   unrank_checker sb;
   int            accepted_count = 0;
   int            cycles = 0;

   bounded_weight_string_unrank #(
      .MAX_BITS(MAX_BITS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_rank        (req_rank),
      .rsp_valid       (rsp_valid),
      .rsp_bits        (rsp_bits),
      .rsp_out_of_range(rsp_out_of_range),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // results are checked before the new transfer is noted so an empty queue stays empty
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_result(rsp_bits, rsp_out_of_range);
         if (start && !busy) begin
            sb.note_rank(req_rank);
            accepted_count <= accepted_count + 1;
         end
         if (csr_we) sb.write_reg(csr_index, csr_wdata);
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_rank(input logic [bwsu_pkg::RANK_W-1:0] rank, input int idle_pct);
      int seen;
      seen = accepted_count;
      start <= 1'b1;
      req_rank <= rank;
      do @(negedge clock); while (accepted_count == seen);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [bwsu_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bwsu_pkg::CFG_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input int length, input int weight);
      drain();
      write_csr(bwsu_pkg::REG_BIT_COUNT, bwsu_pkg::CFG_W'(length));
      write_csr(bwsu_pkg::REG_MAX_ONES, bwsu_pkg::CFG_W'(weight));
      write_csr($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, bwsu_pkg::CFG_W'($urandom));
   endtask

   // mostly valid ranks, some at the boundaries, some anywhere in the field
   function automatic logic [bwsu_pkg::RANK_W-1:0] rand_rank(input longint unsigned total);
      int              pick;
      longint unsigned rnd;
      pick = $urandom_range(99);
      rnd = {$urandom, $urandom};
      if (pick < 70) return bwsu_pkg::RANK_W'(rnd % total + 1);
      if (pick < 85) begin
         case ($urandom_range(3))
            0: return bwsu_pkg::RANK_W'(1);
            1: return bwsu_pkg::RANK_W'(total);
            2: return bwsu_pkg::RANK_W'(total + 1);
            default: return '0;
         endcase
      end
      return {1'($urandom_range(1)), 32'($urandom)};
   endfunction

   initial begin
      int fixed_length [FIXED_PHASES];
      int fixed_weight [FIXED_PHASES];
      int idle_pcts [3];
      int length;
      int weight;
      int idle_pct;

      fixed_length = '{32, 20, 16, 1, 32, 12, 0, 63};
      fixed_weight = '{32, 5, 40, 0, 1, 12, 3, 0};
      idle_pcts = '{0, 78, 15};

      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset setting: 8 bits, up to 8 ones, 256 strings
      send_rank(33'h0, 0);
      send_rank(33'h1, 0);
      send_rank(33'h2, 0);
      send_rank(33'd255, 0);
      send_rank(33'd256, 0);
      send_rank(33'd257, 0);
      send_rank(33'h1FFFFFFFF, 0);
      send_rank(33'h155555555, 0);
      send_rank(33'h0AAAAAAAA, 0);

      set_config(32, 32);
      send_rank(33'h1, 0);
      send_rank(33'h100000000, 0);
      send_rank(33'h100000001, 0);
      send_rank(33'h080000000, 0);
      send_rank(33'h0FFFFFFFF, 0);

      // no ones allowed: only the all-zero string
      set_config(32, 0);
      send_rank(33'h1, 0);
      send_rank(33'h2, 0);

      // zero length: only rank one is valid
      set_config(0, 0);
      send_rank(33'h1, 0);
      send_rank(33'h2, 0);

      // weight bound above the length
      set_config(6, 63);
      send_rank(33'd64, 0);
      send_rank(33'd65, 0);

      // length above the parameter
      set_config(63, 1);
      send_rank(33'd33, 0);
      send_rank(33'd34, 0);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph < FIXED_PHASES) begin
            length = fixed_length[ph];
            weight = fixed_weight[ph];
         end else begin
            length = $urandom_range(63);
            weight = $urandom_range(63);
         end
         idle_pct = idle_pcts[ph % 3];
         set_config(length, weight);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i == ITEMS_PER_PHASE / 2) drain();
            send_rank(rand_rank(sb.string_total()), idle_pct);
         end
      end

      drain();
      repeat (LATENCY + 4) @(negedge clock);
      if (sb.pending() != 0) begin
         $error("%0d results never arrived", sb.pending());
         sb.mismatches++;
      end
      if (sb.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### sim.f
rtl/bwsu_pkg.sv
rtl/bwsu_stage.sv
rtl/bounded_weight_string_unrank.sv
verif/bounded_weight_string_unrank_tb.sv
